// ----- hdl/synth_voice_allocator_assert.svh -----
// Assertion macros for the voice allocator.
`ifndef SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SVA_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/svalloc_pkg.sv -----
// Shared constants and types for the voice allocator.
package svalloc_pkg;
	localparam int NUM_VOICES = 16;
	localparam int VOICE_W    = $clog2(NUM_VOICES);
	localparam int NOTE_W     = 7;
	localparam int NUM_NOTES  = 128;
	localparam int OWNER_W    = 2;
	localparam int VI_W       = 4;
	localparam int LEVEL_W    = 16;
	localparam int AGE_W      = 32;
	localparam int MASK_W     = 16;
	localparam int KIND_W     = 3;

	localparam logic [OWNER_W-1:0] KEY_OWNER = '0;

	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LEVEL    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ENDED    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ALL_OFF  = 3'd4;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_START   = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_UPDATE  = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_START,
		OP_STOP,
		OP_ALLOFF,
		OP_LEVEL,
		OP_ENDED
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic needs_scan;
		logic scan_last;
		logic out_free;
	} sts_t;
endpackage

// ----- hdl/synth_voice_allocator.sv -----
// Flow: level, voice-ended and ignored requests go from accept through the FINISH state to
// the output register; note on, note off and all notes off first make one pass over the table.
// One request at a time: the next is accepted only after the last one is committed;
// a result waiting on m_tready stalls the next commit.
// Reset (arst_n low): table, latches, age counter and hold_mode clear at once.
module synth_voice_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // note[6:0], owner[8:7], voice_index[12:9], voice_level[28:13]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // chosen_voice[3:0], stolen[4], release_mask[20:5]
	output logic [1:0]  m_tuser,  // action[1:0]
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	svalloc_pkg::cmd_t   cmd;
	svalloc_pkg::sts_t   sts;
	svalloc_pkg::state_t state;
	svalloc_pkg::act_t   action;
	logic                hold_mode_q;
	logic [3:0]          chosen_voice;
	logic                stolen;
	logic [15:0]         release_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_mode_q <= 1'b0;
		end else if (cfg_we) begin
			hold_mode_q <= cfg_wdata;
		end
	end

	svalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	svalloc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.hold_mode    (hold_mode_q),
		.kind         (s_tuser),
		.note         (s_tdata[6:0]),
		.owner        (s_tdata[8:7]),
		.voice_index  (s_tdata[12:9]),
		.voice_level  (s_tdata[28:13]),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.action       (action),
		.chosen_voice (chosen_voice),
		.stolen       (stolen),
		.release_mask (release_mask)
	);

	assign m_tuser = action;
	assign m_tdata = {3'b000, release_mask, stolen, chosen_voice};

`include "synth_voice_allocator_assert.svh"

	`SVA_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request accepted while busy")
	`SVA_IMPLY(a_ready_idle, s_tready, state == svalloc_pkg::ST_IDLE, "ready outside idle")
	`SVA_IMPLY(a_start_no_mask, m_tvalid && action == svalloc_pkg::ACT_START, release_mask == '0, "mask on start")
	`SVA_IMPLY(a_mask_only_release, m_tvalid && release_mask != '0, action == svalloc_pkg::ACT_RELEASE, "bad mask")
endmodule

// ----- hdl/svalloc_ctrl.sv -----
// Controller state machine: accept, scan the voice table, commit the result.
module svalloc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  svalloc_pkg::sts_t   sts,
	output svalloc_pkg::cmd_t   cmd,
	output svalloc_pkg::state_t state
);
	svalloc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svalloc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		s_tready   = 1'b0;
		case (state_q)
			svalloc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = sts.needs_scan ? svalloc_pkg::ST_SCAN : svalloc_pkg::ST_FINISH;
				end
			end
			svalloc_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = svalloc_pkg::ST_FINISH;
				end
			end
			svalloc_pkg::ST_FINISH: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = svalloc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = svalloc_pkg::ST_IDLE;
			end
		endcase
	end

	assign state = state_q;
endmodule

// ----- hdl/svalloc_dp.sv -----
// Datapath: voice table, key latches, age counter, scan candidates, output register.
module svalloc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  svalloc_pkg::cmd_t                    cmd,
	output svalloc_pkg::sts_t                    sts,
	input  logic                                 hold_mode,
	input  logic [svalloc_pkg::KIND_W-1:0]       kind,
	input  logic [svalloc_pkg::NOTE_W-1:0]       note,
	input  logic [svalloc_pkg::OWNER_W-1:0]      owner,
	input  logic [svalloc_pkg::VI_W-1:0]         voice_index,
	input  logic [svalloc_pkg::LEVEL_W-1:0]      voice_level,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output svalloc_pkg::act_t                    action,
	output logic [svalloc_pkg::VI_W-1:0]         chosen_voice,
	output logic                                 stolen,
	output logic [svalloc_pkg::MASK_W-1:0]       release_mask
);
	localparam int NV = svalloc_pkg::NUM_VOICES;
	localparam int VW = svalloc_pkg::VOICE_W;

	logic [NV-1:0]                       active_q, releasing_q;
	logic [svalloc_pkg::NOTE_W-1:0]      vnote_q  [NV];
	logic [svalloc_pkg::OWNER_W-1:0]     vowner_q [NV];
	logic [svalloc_pkg::LEVEL_W-1:0]     vloud_q  [NV];
	logic [svalloc_pkg::AGE_W-1:0]       vage_q   [NV];
	logic [svalloc_pkg::AGE_W-1:0]       age_ctr_q;
	logic [svalloc_pkg::NUM_NOTES-1:0]   latch_q;

	svalloc_pkg::op_t                    op_q, op_d;
	logic [svalloc_pkg::NOTE_W-1:0]      note_q;
	logic [svalloc_pkg::OWNER_W-1:0]     owner_q;
	logic [VW-1:0]                       vi_q;
	logic [svalloc_pkg::LEVEL_W-1:0]     level_q;
	logic [VW-1:0]                       idx_q;

	logic                                match_f_q, free_f_q, rel_f_q;
	logic [VW-1:0]                       match_i_q, free_i_q, rel_i_q, old_i_q;
	logic [svalloc_pkg::LEVEL_W-1:0]     rel_lvl_q;
	logic [svalloc_pkg::AGE_W-1:0]       old_age_q;
	logic [svalloc_pkg::MASK_W-1:0]      mask_q;

	logic                                m_tvalid_q, stolen_q;
	svalloc_pkg::act_t                   action_q;
	logic [svalloc_pkg::VI_W-1:0]        chosen_q;
	logic [svalloc_pkg::MASK_W-1:0]      rmask_q;

	logic latch_set, latch_clr, latch_all, vi_ok;
	logic cur_act, cur_rel, cur_hit, rel_sel;
	logic [VW-1:0] pick;
	logic pick_stolen;

	assign vi_ok = 32'(voice_index) < NV;

	// decode the request at accept
	always_comb begin
		op_d      = svalloc_pkg::OP_NONE;
		latch_set = 1'b0;
		latch_clr = 1'b0;
		latch_all = 1'b0;
		case (kind)
			svalloc_pkg::KIND_NOTE_ON: begin
				if (owner == svalloc_pkg::KEY_OWNER && hold_mode && latch_q[note]) begin
					op_d      = svalloc_pkg::OP_STOP;
					latch_clr = 1'b1;
				end else begin
					op_d      = svalloc_pkg::OP_START;
					latch_set = owner == svalloc_pkg::KEY_OWNER;
				end
			end
			svalloc_pkg::KIND_NOTE_OFF: begin
				if (!(owner == svalloc_pkg::KEY_OWNER && hold_mode)) begin
					op_d      = svalloc_pkg::OP_STOP;
					latch_clr = owner == svalloc_pkg::KEY_OWNER;
				end
			end
			svalloc_pkg::KIND_LEVEL: begin
				if (vi_ok) op_d = svalloc_pkg::OP_LEVEL;
			end
			svalloc_pkg::KIND_ENDED: begin
				if (vi_ok) op_d = svalloc_pkg::OP_ENDED;
			end
			svalloc_pkg::KIND_ALL_OFF: begin
				op_d      = svalloc_pkg::OP_ALLOFF;
				latch_all = 1'b1;
			end
			default: begin
				op_d = svalloc_pkg::OP_NONE;
			end
		endcase
	end

	assign sts.needs_scan = op_d == svalloc_pkg::OP_START || op_d == svalloc_pkg::OP_STOP ||
		op_d == svalloc_pkg::OP_ALLOFF;
	assign sts.scan_last  = idx_q == VW'(NV - 1);
	assign sts.out_free   = !m_tvalid_q || m_tready;

	assign cur_act = active_q[idx_q];
	assign cur_rel = releasing_q[idx_q];
	assign cur_hit = cur_act && vnote_q[idx_q] == note_q && vowner_q[idx_q] == owner_q;
	assign rel_sel = (op_q == svalloc_pkg::OP_STOP && cur_hit) ||
		(op_q == svalloc_pkg::OP_ALLOFF && cur_act);

	// priority: same note and owner, free voice, quietest releasing, oldest
	always_comb begin
		pick_stolen = 1'b0;
		if (match_f_q) begin
			pick = match_i_q;
		end else if (free_f_q) begin
			pick = free_i_q;
		end else if (rel_f_q) begin
			pick        = rel_i_q;
			pick_stolen = 1'b1;
		end else begin
			pick        = old_i_q;
			pick_stolen = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			releasing_q <= '0;
			for (int i = 0; i < NV; i++) begin
				vnote_q[i]  <= '0;
				vowner_q[i] <= '0;
				vloud_q[i]  <= '0;
				vage_q[i]   <= '0;
			end
			age_ctr_q  <= '0;
			latch_q    <= '0;
			op_q       <= svalloc_pkg::OP_NONE;
			idx_q      <= '0;
			match_f_q  <= 1'b0;
			free_f_q   <= 1'b0;
			rel_f_q    <= 1'b0;
			mask_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q      <= op_d;
				note_q    <= note;
				owner_q   <= owner;
				vi_q      <= VW'(voice_index);
				level_q   <= voice_level;
				idx_q     <= '0;
				match_f_q <= 1'b0;
				free_f_q  <= 1'b0;
				rel_f_q   <= 1'b0;
				mask_q    <= '0;
				if (latch_all) latch_q <= '0;
				else if (latch_clr) latch_q[note] <= 1'b0;
				else if (latch_set) latch_q[note] <= 1'b1;
			end

			if (cmd.scan) begin
				idx_q <= idx_q + VW'(1);
				if (rel_sel) begin
					releasing_q[idx_q] <= 1'b1;
					if (!cur_rel && 32'(idx_q) < svalloc_pkg::MASK_W) begin
						mask_q <= mask_q | (svalloc_pkg::MASK_W'(1) << idx_q);
					end
				end
				if (op_q == svalloc_pkg::OP_START) begin
					if (cur_hit && !match_f_q) begin
						match_f_q <= 1'b1;
						match_i_q <= idx_q;
					end
					if (!cur_act && !free_f_q) begin
						free_f_q <= 1'b1;
						free_i_q <= idx_q;
					end
					if (cur_rel && (!rel_f_q || vloud_q[idx_q] < rel_lvl_q)) begin
						rel_f_q   <= 1'b1;
						rel_i_q   <= idx_q;
						rel_lvl_q <= vloud_q[idx_q];
					end
					if (idx_q == '0 || vage_q[idx_q] < old_age_q) begin
						old_i_q   <= idx_q;
						old_age_q <= vage_q[idx_q];
					end
				end
			end

			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
				case (op_q)
					svalloc_pkg::OP_START: begin
						action_q          <= svalloc_pkg::ACT_START;
						chosen_q          <= svalloc_pkg::VI_W'(pick);
						stolen_q          <= pick_stolen;
						rmask_q           <= '0;
						age_ctr_q         <= age_ctr_q + svalloc_pkg::AGE_W'(1);
						vage_q[pick]      <= age_ctr_q + svalloc_pkg::AGE_W'(1);
						active_q[pick]    <= 1'b1;
						releasing_q[pick] <= 1'b0;
						vnote_q[pick]     <= note_q;
						vowner_q[pick]    <= owner_q;
					end
					svalloc_pkg::OP_STOP, svalloc_pkg::OP_ALLOFF: begin
						action_q <= svalloc_pkg::ACT_RELEASE;
						chosen_q <= '0;
						stolen_q <= 1'b0;
						rmask_q  <= mask_q;
					end
					svalloc_pkg::OP_LEVEL: begin
						action_q      <= svalloc_pkg::ACT_UPDATE;
						chosen_q      <= '0;
						stolen_q      <= 1'b0;
						rmask_q       <= '0;
						vloud_q[vi_q] <= level_q;
					end
					svalloc_pkg::OP_ENDED: begin
						action_q          <= svalloc_pkg::ACT_UPDATE;
						chosen_q          <= '0;
						stolen_q          <= 1'b0;
						rmask_q           <= '0;
						active_q[vi_q]    <= 1'b0;
						releasing_q[vi_q] <= 1'b0;
					end
					default: begin
						action_q <= svalloc_pkg::ACT_NONE;
						chosen_q <= '0;
						stolen_q <= 1'b0;
						rmask_q  <= '0;
					end
				endcase
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign action       = action_q;
	assign chosen_voice = chosen_q;
	assign stolen       = stolen_q;
	assign release_mask = rmask_q;
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the voice allocator: directed and random requests against a behavioral table.
module tb_top;
	import svalloc_pkg::*;

	typedef struct packed {
		logic [2:0]  kind;
		logic [6:0]  note;
		logic [1:0]  owner;
		logic [3:0]  vidx;
		logic [15:0] level;
	} req_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  voice;
		logic        stolen;
		logic [15:0] mask;
	} rsp_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we = 0;
	logic cfg_wdata = 0;

	synth_voice_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// behavioral voice table
	logic        v_act [NUM_VOICES];
	logic        v_rel [NUM_VOICES];
	logic [6:0]  v_note [NUM_VOICES];
	logic [1:0]  v_own [NUM_VOICES];
	logic [15:0] v_loud [NUM_VOICES];
	logic [31:0] v_age [NUM_VOICES];
	logic [31:0] age_now;
	logic        latched [NUM_NOTES];
	logic        hold;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int errors = 0;
	int send_idle = 38, recv_idle = 81;
	bit pause_send = 0;

	function automatic logic [15:0] release_voice(int i);
		logic [15:0] b;
		b = '0;
		if (v_act[i] && !v_rel[i] && i < 16) b[i] = 1'b1;
		if (v_act[i]) v_rel[i] = 1'b1;
		return b;
	endfunction

	function automatic logic [15:0] stop_matching(logic [6:0] n, logic [1:0] o);
		logic [15:0] m;
		m = '0;
		for (int i = 0; i < NUM_VOICES; i++)
			if (v_act[i] && v_note[i] == n && v_own[i] == o) m |= release_voice(i);
		return m;
	endfunction

	function automatic int pick_voice(logic [6:0] n, logic [1:0] o);
		int best;
		for (int i = 0; i < NUM_VOICES; i++)
			if (v_act[i] && v_note[i] == n && v_own[i] == o) return i;
		for (int i = 0; i < NUM_VOICES; i++)
			if (!v_act[i]) return i;
		best = -1;
		for (int i = 0; i < NUM_VOICES; i++)
			if (v_rel[i] && (best < 0 || v_loud[i] < v_loud[best])) best = i;
		if (best >= 0) return best;
		best = 0;
		for (int i = 1; i < NUM_VOICES; i++)
			if (v_age[i] < v_age[best]) best = i;
		return best;
	endfunction

	function automatic rsp_t allocate(req_t r);
		rsp_t x;
		int v;
		x = '0;
		case (r.kind)
			KIND_NOTE_ON: begin
				if (r.owner == KEY_OWNER && hold && latched[r.note]) begin
					latched[r.note] = 1'b0;
					x.action = ACT_RELEASE;
					x.mask = stop_matching(r.note, r.owner);
				end else begin
					if (r.owner == KEY_OWNER) latched[r.note] = 1'b1;
					v = pick_voice(r.note, r.owner);
					x.stolen = v_act[v] && (v_note[v] != r.note || v_own[v] != r.owner);
					age_now = age_now + 1;
					v_age[v] = age_now;
					v_act[v] = 1'b1;
					v_rel[v] = 1'b0;
					v_note[v] = r.note;
					v_own[v] = r.owner;
					x.action = ACT_START;
					x.voice = v[3:0];
				end
			end
			KIND_NOTE_OFF: begin
				if (!(r.owner == KEY_OWNER && hold)) begin
					if (r.owner == KEY_OWNER) latched[r.note] = 1'b0;
					x.action = ACT_RELEASE;
					x.mask = stop_matching(r.note, r.owner);
				end
			end
			KIND_LEVEL: begin
				v_loud[r.vidx] = r.level;
				x.action = ACT_UPDATE;
			end
			KIND_ENDED: begin
				v_act[r.vidx] = 1'b0;
				v_rel[r.vidx] = 1'b0;
				x.action = ACT_UPDATE;
			end
			KIND_ALL_OFF: begin
				for (int i = 0; i < NUM_NOTES; i++) latched[i] = 1'b0;
				for (int i = 0; i < NUM_VOICES; i++) x.mask |= release_voice(i);
				x.action = ACT_RELEASE;
			end
			default: ;
		endcase
		return x;
	endfunction

	// driver; while paused, hold each request until all earlier results are back
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 &&
						!(pause_send && expected_rsps.size() > 0) &&
						$urandom_range(99) >= send_idle) begin
					req_t r;
					r = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= r.kind;
					s_tdata <= {3'b0, r.level, r.vidx, r.owner, r.note};
					expected_rsps.push_back(allocate(r));
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor
	int quiet = 0;
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			rsp_t e;
			quiet <= 0;
			if (expected_rsps.size() == 0) begin
				$error("unexpected result action=%0d", m_tuser);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (m_tuser != e.action) begin
					$error("action exp %0d got %0d", e.action, m_tuser); errors++;
				end
				if (m_tdata[3:0] != e.voice) begin
					$error("chosen_voice exp %0d got %0d", e.voice, m_tdata[3:0]); errors++;
				end
				if (m_tdata[4] != e.stolen) begin
					$error("stolen exp %0d got %0d", e.stolen, m_tdata[4]); errors++;
				end
				if (m_tdata[20:5] != e.mask) begin
					$error("release_mask exp %h got %h", e.mask, m_tdata[20:5]); errors++;
				end
			end
		end else if (s_tvalid && s_tready) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet > 20000) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	function automatic req_t rand_req();
		req_t r;
		int k;
		r.kind = 3'($urandom_range(99) < 3 ? $urandom_range(7, 5) : 0);
		k = $urandom_range(99);
		if (r.kind == 0) begin
			if (k < 40) r.kind = KIND_NOTE_ON;
			else if (k < 68) r.kind = KIND_NOTE_OFF;
			else if (k < 82) r.kind = KIND_LEVEL;
			else if (k < 96) r.kind = KIND_ENDED;
			else r.kind = KIND_ALL_OFF;
		end
		// narrow note range so presses and releases meet
		r.note = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(60, 67));
		r.owner = 2'($urandom);
		r.vidx = 4'($urandom);
		r.level = 16'($urandom);
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (NUM_VOICES + 6) @(posedge clk);
	endtask

	task automatic set_hold(bit h);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		hold = h;
	endtask

	task automatic push(logic [2:0] k, logic [6:0] n, logic [1:0] o, logic [3:0] vi,
			logic [15:0] lv);
		pending_reqs.push_back('{kind: k, note: n, owner: o, vidx: vi, level: lv});
	endtask

	initial begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			v_act[i] = 0; v_rel[i] = 0; v_note[i] = 0; v_own[i] = 0;
			v_loud[i] = 0; v_age[i] = 0;
		end
		for (int i = 0; i < NUM_NOTES; i++) latched[i] = 0;
		age_now = 0;
		hold = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: fill all voices, steal, extremes, unknown kinds
		for (int i = 0; i < 17; i++) push(KIND_NOTE_ON, 7'(i * 7 + 1), 2'(i), 4'(0), 16'(0));
		push(KIND_LEVEL, 0, 0, 4'd15, 16'hFFFF);
		push(KIND_LEVEL, 0, 0, 4'd3, 16'h0000);
		push(KIND_NOTE_OFF, 7'd127, 2'd3, 0, 0);
		push(KIND_NOTE_OFF, 7'd0, 2'd0, 0, 0);
		push(KIND_ENDED, 0, 0, 4'd15, 0);
		push(3'd7, 7'd127, 2'd3, 4'd15, 16'hFFFF);
		push(3'd5, 0, 0, 0, 0);
		push(KIND_ALL_OFF, 0, 0, 0, 0);
		push(KIND_NOTE_ON, 7'd127, 2'd3, 0, 0);
		wait_drained();

		// hold mode: double press releases, key note-off ignored
		set_hold(1);
		push(KIND_NOTE_ON, 7'd60, 2'd0, 0, 0);
		push(KIND_NOTE_OFF, 7'd60, 2'd0, 0, 0);
		push(KIND_NOTE_ON, 7'd60, 2'd0, 0, 0);
		push(KIND_NOTE_ON, 7'd60, 2'd0, 0, 0);
		for (int i = 0; i < 330; i++) pending_reqs.push_back(rand_req());
		wait_drained();

		// sender waits for everything to come back before each request
		pause_send = 1;
		push(KIND_NOTE_ON, 7'd61, 2'd1, 0, 0);
		push(KIND_NOTE_ON, 7'd62, 2'd2, 0, 0);
		push(KIND_NOTE_ON, 7'd63, 2'd3, 0, 0);
		push(KIND_ALL_OFF, 0, 0, 0, 0);
		wait_drained();
		pause_send = 0;

		set_hold(0);
		send_idle = 81; recv_idle = 38;
		for (int i = 0; i < 330; i++) pending_reqs.push_back(rand_req());
		wait_drained();

		set_hold(1);
		send_idle = 0; recv_idle = 0;
		for (int i = 0; i < 330; i++) pending_reqs.push_back(rand_req());
		wait_drained();

		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
